@@ hw/rtl/cbpn_pkg.sv @@
package cbpn_pkg;

   localparam int COORD_BITS = 32;
   localparam int PARAM_BITS = 16;
   localparam int T_BITS     = PARAM_BITS + 1;
   localparam int NORM_BITS  = 16;
   localparam int UNIT_Q14   = 16384;
   localparam int CSR_IDX_BITS = 3;
   localparam int WIDE_BITS  = COORD_BITS + 2;
   localparam int MAG_BITS   = 24;
   localparam int SQ_BITS    = 2 * MAG_BITS + 1;
   localparam int ROOT_BITS  = 25;
   localparam int QUO_BITS   = 15;
   localparam int NUM_BITS   = MAG_BITS + 15;

   localparam logic [CSR_IDX_BITS-1:0] REG_START_X  = 3'd0;
   localparam logic [CSR_IDX_BITS-1:0] REG_START_Y  = 3'd1;
   localparam logic [CSR_IDX_BITS-1:0] REG_CTRL1_X  = 3'd2;
   localparam logic [CSR_IDX_BITS-1:0] REG_CTRL1_Y  = 3'd3;
   localparam logic [CSR_IDX_BITS-1:0] REG_CTRL2_X  = 3'd4;
   localparam logic [CSR_IDX_BITS-1:0] REG_CTRL2_Y  = 3'd5;
   localparam logic [CSR_IDX_BITS-1:0] REG_FINISH_X = 3'd6;
   localparam logic [CSR_IDX_BITS-1:0] REG_FINISH_Y = 3'd7;

   typedef struct packed {
      logic signed [WIDE_BITS-1:0] px;
      logic signed [WIDE_BITS-1:0] py;
      logic signed [WIDE_BITS-1:0] dx;
      logic signed [WIDE_BITS-1:0] dy;
   } front_item_type;

   typedef struct packed {
      logic signed [COORD_BITS-1:0] point_x;
      logic signed [COORD_BITS-1:0] point_y;
      logic signed [NORM_BITS-1:0]  normal_x;
      logic signed [NORM_BITS-1:0]  normal_y;
      logic                         zero_tangent;
   } result_type;

   function automatic logic signed [WIDE_BITS-1:0] clamp_coord(
      input logic signed [WIDE_BITS-1:0] v);
      logic signed [WIDE_BITS-1:0] hi;
      logic signed [WIDE_BITS-1:0] lo;
      hi = WIDE_BITS'((64'sd1 <<< (COORD_BITS - 1)) - 64'sd1);
      lo = -hi - WIDE_BITS'(1);
      if (v > hi) return hi;
      if (v < lo) return lo;
      return v;
   endfunction

endpackage

@@ hw/rtl/cbpn_lerp.sv @@
// one pipelined rounded interpolation: a + round((b-a)*t), two stages
module cbpn_lerp (
   input  logic                                 clock,
   input  logic                                 en,
   input  logic signed [cbpn_pkg::WIDE_BITS-1:0] a,
   input  logic signed [cbpn_pkg::WIDE_BITS-1:0] b,
   input  logic        [cbpn_pkg::T_BITS-1:0]    t,
   output logic signed [cbpn_pkg::WIDE_BITS-1:0] res
);
   import cbpn_pkg::*;

   localparam int DB = WIDE_BITS + 1;
   localparam int PB = DB + T_BITS;

   logic          [DB-1:0] mag;
   logic          [PB-1:0] prod_in, prod_ff;
   logic signed   [DB-1:0] diff;
   logic                   neg_ff;
   logic signed [WIDE_BITS-1:0] a_ff;
   logic          [PB-1:0] rnd;
   logic signed [WIDE_BITS-1:0] res_in, res_ff;

   always_comb begin
      diff = DB'(b) - DB'(a);
      mag = diff[DB-1] ? DB'(-diff) : DB'(diff);
      prod_in = PB'(mag) * PB'(t);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff <= prod_in;
         neg_ff  <= diff[DB-1];
         a_ff    <= a;
         res_ff  <= res_in;
      end
   end

   always_comb begin
      rnd = (prod_ff + PB'(1 << (PARAM_BITS - 1))) >> PARAM_BITS;
      res_in = neg_ff ? WIDE_BITS'(a_ff - $signed(WIDE_BITS'(rnd)))
                      : WIDE_BITS'(a_ff + $signed(WIDE_BITS'(rnd)));
   end

   assign res = res_ff;
endmodule

@@ hw/rtl/cbpn_front.sv @@
// de Casteljau pipeline: three lerp levels of two stages each
module cbpn_front (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              en,
   input  logic                              in_valid,
   input  logic [cbpn_pkg::T_BITS-1:0]       in_t,
   input  logic signed [cbpn_pkg::COORD_BITS-1:0] ctl [8],
   output logic                              out_valid,
   output cbpn_pkg::front_item_type          out_item
);
   import cbpn_pkg::*;

   localparam int DEPTH = 6;

   logic [DEPTH-1:0] vld_ff;
   logic [T_BITS-1:0] t0, t2_ff, t4_ff, t1_ff, t3_ff;
   logic signed [WIDE_BITS-1:0] q [6];
   logic signed [WIDE_BITS-1:0] r [4];
   logic signed [WIDE_BITS-1:0] p [2];
   logic signed [WIDE_BITS-1:0] rd_ff [4];
   logic signed [WIDE_BITS-1:0] rd2_ff [4];

   assign t0 = (in_t > T_BITS'(1 << PARAM_BITS)) ? T_BITS'(1 << PARAM_BITS) : in_t;

   for (genvar k = 0; k < 6; k++) begin : g_l1
      cbpn_lerp u_l (.clock, .en, .a(WIDE_BITS'(ctl[k])), .b(WIDE_BITS'(ctl[k + 2])),
                     .t(t0), .res(q[k]));
   end
   for (genvar k = 0; k < 4; k++) begin : g_l2
      cbpn_lerp u_l (.clock, .en, .a(q[k]), .b(q[k + 2]), .t(t2_ff), .res(r[k]));
   end
   for (genvar k = 0; k < 2; k++) begin : g_l3
      cbpn_lerp u_l (.clock, .en, .a(r[k]), .b(r[k + 2]), .t(t4_ff), .res(p[k]));
   end

   always_ff @(posedge clock) begin
      if (en) begin
         t1_ff <= t0;
         t2_ff <= t1_ff;
         t3_ff <= t2_ff;
         t4_ff <= t3_ff;
         for (int k = 0; k < 4; k++) begin
            rd_ff[k]  <= r[k];
            rd2_ff[k] <= rd_ff[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) vld_ff <= '0;
      else if (en) vld_ff <= {vld_ff[DEPTH-2:0], in_valid};
   end

   assign out_valid = vld_ff[DEPTH-1];
   always_comb begin
      out_item.px = p[0];
      out_item.py = p[1];
      out_item.dx = rd2_ff[2] - rd2_ff[0];
      out_item.dy = rd2_ff[3] - rd2_ff[1];
   end
endmodule

@@ hw/rtl/cbpn_fifo.sv @@
// short queue between front and back
module cbpn_fifo (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         wr_en,
   input  cbpn_pkg::front_item_type     wr_data,
   input  logic                         rd_en,
   output cbpn_pkg::front_item_type     rd_data,
   output logic                         not_empty,
   output logic [3:0]                   count
);
   import cbpn_pkg::*;

   front_item_type mem_ff [16];
   logic [3:0] wp_ff, rp_ff;
   logic [4:0] cnt_ff;

   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wp_ff] <= wr_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= '0;
         rp_ff <= '0;
         cnt_ff <= '0;
      end else begin
         if (wr_en) wp_ff <= wp_ff + 4'd1;
         if (rd_en) rp_ff <= rp_ff + 4'd1;
         cnt_ff <= cnt_ff + 5'(wr_en) - 5'(rd_en);
      end
   end

   assign rd_data = mem_ff[rp_ff];
   assign not_empty = cnt_ff != 5'd0;
   assign count = cnt_ff[4] ? 4'hF : cnt_ff[3:0];
endmodule

@@ hw/rtl/cbpn_back.sv @@
// normal unit: normalize, bit-serial-per-stage sqrt and divide, fully pipelined
module cbpn_back (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       en,
   input  logic                       in_valid,
   input  cbpn_pkg::front_item_type   in_item,
   output logic                       out_valid,
   output cbpn_pkg::result_type       out_res
);
   import cbpn_pkg::*;

   localparam int SQ_STEPS = 25;
   localparam int DV_STEPS = 16;
   localparam int NST = 3 + SQ_STEPS + DV_STEPS + 1;

   typedef struct packed {
      logic signed [COORD_BITS-1:0] px;
      logic signed [COORD_BITS-1:0] py;
      logic                       zero;
      logic                       sx;
      logic                       sy;
      logic [MAG_BITS-1:0]        a;
      logic [MAG_BITS-1:0]        b;
   } ctl_type;

   ctl_type c_ff [NST];

   // item valid alongside the stage data
   logic [NST-2:0] vp_ff;
   always_ff @(posedge clock) begin
      if (reset) vp_ff <= '0;
      else if (en) vp_ff <= {vp_ff[NST-3:0], in_valid};
   end

   // stage 0: magnitudes
   logic [WIDE_BITS-1:0] am_in, bm_in, am_ff, bm_ff;
   ctl_type c0;
   always_comb begin
      am_in = in_item.dx[WIDE_BITS-1] ? WIDE_BITS'(-in_item.dx) : in_item.dx;
      bm_in = in_item.dy[WIDE_BITS-1] ? WIDE_BITS'(-in_item.dy) : in_item.dy;
      c0 = '0;
      c0.px = COORD_BITS'(clamp_coord(in_item.px));
      c0.py = COORD_BITS'(clamp_coord(in_item.py));
      c0.zero = (in_item.dx == '0) && (in_item.dy == '0);
      c0.sx = in_item.dy[WIDE_BITS-1];
      c0.sy = in_item.dx > 0;
   end

   // stage 1: normalize via leading one of max
   logic [WIDE_BITS-1:0] mx;
   logic [5:0] lead;
   logic [MAG_BITS-1:0] an, bn;
   ctl_type c1;
   always_comb begin
      mx = (am_ff > bm_ff) ? am_ff : bm_ff;
      lead = '0;
      for (int i = 0; i < WIDE_BITS; i++) if (mx[i]) lead = 6'(i);
      if (lead >= 6'(MAG_BITS - 1)) begin
         an = MAG_BITS'(am_ff >> (lead - 6'(MAG_BITS - 1)));
         bn = MAG_BITS'(bm_ff >> (lead - 6'(MAG_BITS - 1)));
      end else begin
         an = MAG_BITS'(am_ff << (6'(MAG_BITS - 1) - lead));
         bn = MAG_BITS'(bm_ff << (6'(MAG_BITS - 1) - lead));
      end
      c1 = c_ff[0];
      c1.a = an;
      c1.b = bn;
   end

   // stage 2: sum of squares
   logic [SQ_BITS-1:0] sq_ff;
   logic [SQ_BITS:0] sv_ff [SQ_STEPS];
   logic [SQ_BITS:0] sr_ff [SQ_STEPS];

   always_ff @(posedge clock) begin
      if (en) begin
         am_ff <= am_in;
         bm_ff <= bm_in;
         c_ff[0] <= c0;
         c_ff[1] <= c1;
         sq_ff <= SQ_BITS'(c_ff[1].a) * SQ_BITS'(c_ff[1].a)
                + SQ_BITS'(c_ff[1].b) * SQ_BITS'(c_ff[1].b);
         c_ff[2] <= c_ff[1];
      end
   end

   // restoring square root, one result bit per stage (bit = 4^(24-k))
   for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sq
      logic [SQ_BITS:0] v_in, v_out;
      logic [SQ_BITS:0] r_in, r_out;
      logic [SQ_BITS:0] bitv, tr;
      always_comb begin
         v_in = (k == 0) ? (SQ_BITS+1)'(sq_ff) : sv_ff[(k == 0) ? 0 : k - 1];
         r_in = (k == 0) ? '0 : sr_ff[(k == 0) ? 0 : k - 1];
         bitv = (SQ_BITS+1)'(1) << (2 * (SQ_STEPS - 1 - k));
         tr = r_in + bitv;
         if (v_in >= tr) begin
            v_out = v_in - tr;
            r_out = (r_in >> 1) + bitv;
         end else begin
            v_out = v_in;
            r_out = r_in >> 1;
         end
      end
      always_ff @(posedge clock) begin
         if (en) begin
            sv_ff[k] <= v_out;
            sr_ff[k] <= r_out;
            c_ff[3 + k] <= c_ff[2 + k];
         end
      end
   end

   // restoring divide, both components, one quotient bit per stage
   localparam int RB = ROOT_BITS;
   logic [RB-1:0] root;
   assign root = RB'(sr_ff[SQ_STEPS-1]);
   logic [RB-1:0] dr_ff [DV_STEPS];
   logic [NUM_BITS:0] nxr_ff [DV_STEPS], nyr_ff [DV_STEPS];
   logic [DV_STEPS-1:0] qx_ff [DV_STEPS], qy_ff [DV_STEPS];
   logic [NUM_BITS:0] nx_num, ny_num;
   logic [RB-1:0] root_nz;
   always_comb begin
      root_nz = (root == '0) ? RB'(1) : root;
      nx_num = (NUM_BITS+1)'(c_ff[SQ_STEPS+2].b) * (NUM_BITS+1)'(UNIT_Q14)
             + (NUM_BITS+1)'(root_nz >> 1);
      ny_num = (NUM_BITS+1)'(c_ff[SQ_STEPS+2].a) * (NUM_BITS+1)'(UNIT_Q14)
             + (NUM_BITS+1)'(root_nz >> 1);
   end

   for (genvar k = 0; k < DV_STEPS; k++) begin : g_dv
      logic [NUM_BITS:0] xi, yi, xo, yo, sh;
      logic [RB-1:0] d;
      logic [DV_STEPS-1:0] qxi, qyi, qxo, qyo;
      always_comb begin
         xi = (k == 0) ? nx_num : nxr_ff[(k == 0) ? 0 : k - 1];
         yi = (k == 0) ? ny_num : nyr_ff[(k == 0) ? 0 : k - 1];
         d  = (k == 0) ? root_nz : dr_ff[(k == 0) ? 0 : k - 1];
         qxi = (k == 0) ? '0 : qx_ff[(k == 0) ? 0 : k - 1];
         qyi = (k == 0) ? '0 : qy_ff[(k == 0) ? 0 : k - 1];
         sh = (NUM_BITS+1)'(d) << (DV_STEPS - 1 - k);
         qxo = qxi; qyo = qyi; xo = xi; yo = yi;
         if (xi >= sh) begin xo = xi - sh; qxo[DV_STEPS-1-k] = 1'b1; end
         if (yi >= sh) begin yo = yi - sh; qyo[DV_STEPS-1-k] = 1'b1; end
      end
      always_ff @(posedge clock) begin
         if (en) begin
            nxr_ff[k] <= xo;
            nyr_ff[k] <= yo;
            dr_ff[k] <= d;
            qx_ff[k] <= qxo;
            qy_ff[k] <= qyo;
            c_ff[SQ_STEPS + 3 + k] <= c_ff[SQ_STEPS + 2 + k];
         end
      end
   end

   ctl_type cl;
   logic [DV_STEPS-1:0] qx, qy;
   logic signed [NORM_BITS-1:0] nx, ny;
   always_comb begin
      cl = c_ff[NST-2];
      qx = qx_ff[DV_STEPS-1];
      qy = qy_ff[DV_STEPS-1];
      if (qx > DV_STEPS'(UNIT_Q14)) qx = DV_STEPS'(UNIT_Q14);
      if (qy > DV_STEPS'(UNIT_Q14)) qy = DV_STEPS'(UNIT_Q14);
      nx = cl.sx ? -$signed(NORM_BITS'(qx)) : $signed(NORM_BITS'(qx));
      ny = cl.sy ? -$signed(NORM_BITS'(qy)) : $signed(NORM_BITS'(qy));
      if (cl.zero) begin nx = '0; ny = '0; end
   end

   result_type res_ff;
   logic vld_ff;
   always_ff @(posedge clock) begin
      if (en) begin
         res_ff.point_x <= cl.px;
         res_ff.point_y <= cl.py;
         res_ff.normal_x <= nx;
         res_ff.normal_y <= ny;
         res_ff.zero_tangent <= cl.zero;
         c_ff[NST-1] <= cl;
      end
   end
   always_ff @(posedge clock) begin
      if (reset) vld_ff <= 1'b0;
      else if (en) vld_ff <= vp_ff[NST-2];
   end

   assign out_valid = vld_ff;
   assign out_res = res_ff;
endmodule

@@ hw/rtl/cubic_bezier_point_normal_core.sv @@
// cubic bezier point and unit normal evaluator
// an accepted push passes the front pipeline, mid queue, back pipeline and output queue
// throughput: one item per cycle unless stalled, via pipelined lerp, sqrt and divide stages
// back pipeline holds while the 32-item output queue is full; full rises at 8 in the mid queue
// reset: synchronous, clears the pipeline valids, queues and control points to zero
module cubic_bezier_point_normal_core (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_push,
   output logic                                   req_full,
   input  logic [cbpn_pkg::T_BITS-1:0]            req_param_t,
   output logic                                   rsp_empty,
   input  logic                                   rsp_pop,
   output logic signed [cbpn_pkg::COORD_BITS-1:0] rsp_point_x,
   output logic signed [cbpn_pkg::COORD_BITS-1:0] rsp_point_y,
   output logic signed [cbpn_pkg::NORM_BITS-1:0]  rsp_normal_x,
   output logic signed [cbpn_pkg::NORM_BITS-1:0]  rsp_normal_y,
   output logic                                   rsp_zero_tangent,
   input  logic                                   csr_wr_en,
   input  logic [cbpn_pkg::CSR_IDX_BITS-1:0]      csr_index,
   input  logic [cbpn_pkg::COORD_BITS-1:0]        csr_wdata
);
   import cbpn_pkg::*;

   logic signed [COORD_BITS-1:0] ctl_ff [8];
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 8; i++) ctl_ff[i] <= '0;
      end else if (csr_wr_en) begin
         ctl_ff[csr_index] <= csr_wdata;
      end
   end

   // front runs free and never stalls; pushes are refused while the middle queue is nearly full
   logic f_valid, q_ne, b_valid, b_en, f_en, q_rd;
   logic [3:0] q_cnt;
   front_item_type f_item, q_item;
   result_type b_res;

   logic push_ok;
   assign f_en = 1'b1;
   assign push_ok = req_push && !req_full;

   cbpn_front u_front (.clock, .reset, .en(f_en), .in_valid(push_ok), .in_t(req_param_t),
                       .ctl(ctl_ff), .out_valid(f_valid), .out_item(f_item));

   cbpn_fifo u_mid (.clock, .reset, .wr_en(f_valid), .wr_data(f_item), .rd_en(q_rd),
                    .rd_data(q_item), .not_empty(q_ne), .count(q_cnt));

   // output queue: the back pipeline holds its items while the queue is full
   result_type oq_ff [32];
   logic [4:0] owp_ff, orp_ff;
   logic [5:0] ocnt_ff;
   logic b_wr;

   assign b_en = ocnt_ff != 6'd32;
   assign q_rd = q_ne && b_en;
   assign b_wr = b_valid && b_en;

   cbpn_back u_back (.clock, .reset, .en(b_en), .in_valid(q_rd), .in_item(q_item),
                     .out_valid(b_valid), .out_res(b_res));

   logic pop_ok;
   assign pop_ok = rsp_pop && !rsp_empty;

   always_ff @(posedge clock) begin
      if (b_wr) oq_ff[owp_ff] <= b_res;
   end
   always_ff @(posedge clock) begin
      if (reset) begin
         owp_ff <= '0;
         orp_ff <= '0;
         ocnt_ff <= '0;
      end else begin
         if (b_wr) owp_ff <= owp_ff + 5'd1;
         if (pop_ok) orp_ff <= orp_ff + 5'd1;
         ocnt_ff <= ocnt_ff + 6'(b_wr) - 6'(pop_ok);
      end
   end

   // middle queue must absorb the items still in the front pipeline
   assign req_full = q_cnt >= 4'd8;

   result_type head;
   assign head = oq_ff[orp_ff];
   assign rsp_empty = ocnt_ff == 6'd0;
   assign rsp_point_x = head.point_x;
   assign rsp_point_y = head.point_y;
   assign rsp_normal_x = head.normal_x;
   assign rsp_normal_y = head.normal_y;
   assign rsp_zero_tangent = head.zero_tangent;
endmodule

@@ tb/tb_cubic_bezier_point_normal_core.sv @@
`timescale 1ns / 100ps

module tb_cubic_bezier_point_normal_core;
   import cbpn_pkg::*;

   typedef enum int {CURVE_ZERO, CURVE_MAX, CURVE_MIN, CURVE_ALTERNATE, CURVE_WIDE,
                     CURVE_NARROW, CURVE_LINE} curve_kind_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_push = 1'b0;
   logic                   req_full;
   logic [T_BITS-1:0]      req_param_t = '0;
   logic                   rsp_empty;
   logic                   rsp_pop = 1'b0;
   logic signed [COORD_BITS-1:0] rsp_point_x;
   logic signed [COORD_BITS-1:0] rsp_point_y;
   logic signed [NORM_BITS-1:0]  rsp_normal_x;
   logic signed [NORM_BITS-1:0]  rsp_normal_y;
   logic                   rsp_zero_tangent;
   logic                   csr_wr_en = 1'b0;
   logic [CSR_IDX_BITS-1:0] csr_index = '0;
   logic [COORD_BITS-1:0]  csr_wdata = '0;

   longint          ctrl_pts[8];
   logic [T_BITS-1:0] pending_params[$];
   result_type      expected_points[$];
   int              push_gap = 0;
   int              pop_gap = 0;
   bit              calm = 1'b0;
   int              errors = 0;

   cubic_bezier_point_normal_core u_top (
      .clock(clock), .reset(reset),
      .req_push(req_push), .req_full(req_full), .req_param_t(req_param_t),
      .rsp_empty(rsp_empty), .rsp_pop(rsp_pop),
      .rsp_point_x(rsp_point_x), .rsp_point_y(rsp_point_y),
      .rsp_normal_x(rsp_normal_x), .rsp_normal_y(rsp_normal_y),
      .rsp_zero_tangent(rsp_zero_tangent),
      .csr_wr_en(csr_wr_en), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // rounded interpolation, half away from zero
   function automatic longint blend(longint a, longint b, longint t);
      longint d;
      longint mag;
      longint r;
      d = b - a;
      mag = (d < 0) ? -d : d;
      r = (mag * t + (64'sd1 <<< (PARAM_BITS - 1))) >>> PARAM_BITS;
      return a + ((d < 0) ? -r : r);
   endfunction

   function automatic longint clip_coord(longint v);
      longint hi;
      hi = (64'sd1 <<< (COORD_BITS - 1)) - 1;
      if (v > hi) return hi;
      if (v < -hi - 1) return -hi - 1;
      return v;
   endfunction

   function automatic longint int_root(longint v);
      longint res;
      longint bitv;
      res = 0;
      bitv = 64'sd1 <<< 62;
      while (bitv > v) bitv = bitv >>> 2;
      while (bitv != 0) begin
         if (v >= res + bitv) begin
            v = v - (res + bitv);
            res = (res >>> 1) + bitv;
         end else begin
            res = res >>> 1;
         end
         bitv = bitv >>> 2;
      end
      return res;
   endfunction

   function automatic longint unit_part(longint m, longint r);
      longint c;
      c = (m * UNIT_Q14 + (r >>> 1)) / r;
      return (c > UNIT_Q14) ? UNIT_Q14 : c;
   endfunction

   function automatic result_type curve_sample(logic [T_BITS-1:0] tin);
      result_type res;
      longint t;
      longint q[6];
      longint r[4];
      longint dx, dy, a, b, mx, rt, nx, ny;
      t = longint'(tin);
      if (t > (64'sd1 <<< PARAM_BITS)) t = 64'sd1 <<< PARAM_BITS;
      for (int ax = 0; ax < 2; ax++) begin
         for (int k = 0; k < 3; k++)
            q[k*2+ax] = blend(ctrl_pts[k*2+ax], ctrl_pts[k*2+2+ax], t);
         r[ax] = blend(q[ax], q[2+ax], t);
         r[2+ax] = blend(q[2+ax], q[4+ax], t);
      end
      res.point_x = COORD_BITS'(clip_coord(blend(r[0], r[2], t)));
      res.point_y = COORD_BITS'(clip_coord(blend(r[1], r[3], t)));
      dx = r[2] - r[0];
      dy = r[3] - r[1];
      nx = 0;
      ny = 0;
      res.zero_tangent = (dx == 0 && dy == 0);
      if (!res.zero_tangent) begin
         a = (dx < 0) ? -dx : dx;
         b = (dy < 0) ? -dy : dy;
         mx = (a > b) ? a : b;
         while (mx >= (64'sd1 <<< 24)) begin a = a >>> 1; b = b >>> 1; mx = mx >>> 1; end
         while (mx < (64'sd1 <<< 23)) begin a = a <<< 1; b = b <<< 1; mx = mx <<< 1; end
         rt = int_root(a * a + b * b);
         nx = unit_part(b, rt);
         ny = unit_part(a, rt);
         if (dy < 0) nx = -nx;
         if (dx > 0) ny = -ny;
      end
      res.normal_x = nx[NORM_BITS-1:0];
      res.normal_y = ny[NORM_BITS-1:0];
      return res;
   endfunction

   task automatic check_field(string name, longint want, longint got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         errors++;
      end
   endtask

   // stimulus side
   always @(posedge clock) begin
      bit go;
      if (reset) begin
         req_push <= 1'b0;
      end else begin
         if (req_push && !req_full) begin
            expected_points.push_back(curve_sample(req_param_t));
            void'(pending_params.pop_front());
         end
         go = 1'b0;
         if (push_gap > 0) push_gap--;
         else if (!calm && $urandom_range(0, 9) == 0) push_gap = $urandom_range(0, 7);
         else go = (pending_params.size() > 0);
         req_push <= go;
         if (go) req_param_t <= pending_params[0];
      end
   end

   // result side
   always @(posedge clock) begin
      bit take;
      result_type want;
      if (reset) begin
         rsp_pop <= 1'b0;
      end else begin
         if (rsp_pop && !rsp_empty) begin
            if (expected_points.size() == 0) begin
               $display("%0t: unexpected item, actual x %0d y %0d", $time,
                        rsp_point_x, rsp_point_y);
               errors++;
            end else begin
               want = expected_points.pop_front();
               check_field("point_x", want.point_x, rsp_point_x);
               check_field("point_y", want.point_y, rsp_point_y);
               check_field("normal_x", want.normal_x, rsp_normal_x);
               check_field("normal_y", want.normal_y, rsp_normal_y);
               check_field("zero_tangent", want.zero_tangent, rsp_zero_tangent);
            end
         end
         take = 1'b0;
         if (pop_gap > 0) pop_gap--;
         else if (!calm && $urandom_range(0, 7) == 0) pop_gap = $urandom_range(0, 7);
         else take = 1'b1;
         rsp_pop <= take;
      end
   end

   task automatic write_reg(logic [CSR_IDX_BITS-1:0] idx, logic [COORD_BITS-1:0] val);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      ctrl_pts[idx] = longint'(signed'(val));
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic set_curve(curve_kind_type kind);
      logic [COORD_BITS-1:0] v;
      logic [COORD_BITS-1:0] base;
      base = $urandom;
      for (int i = 0; i < 8; i++) begin
         case (kind)
            CURVE_ZERO:      v = '0;
            CURVE_MAX:       v = {1'b0, {(COORD_BITS-1){1'b1}}};
            CURVE_MIN:       v = {1'b1, {(COORD_BITS-1){1'b0}}};
            CURVE_ALTERNATE: v = ((i / 2 + i) % 2) ? {1'b0, {(COORD_BITS-1){1'b1}}}
                                                   : {1'b1, {(COORD_BITS-1){1'b0}}};
            CURVE_WIDE:      v = $urandom;
            CURVE_NARROW:    v = $urandom_range(0, 2000) - 1000;
            // collinear points on a line of constant y; the tangent stays nonzero at the ends
            default:         v = (i % 2) ? base : base + (i / 2) * 32'h0001_0000;
         endcase
         write_reg(i[CSR_IDX_BITS-1:0], v);
      end
   endtask

   task automatic drain();
      while (pending_params.size() > 0 || expected_points.size() > 0) @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   task automatic add_random(int count);
      repeat (count) begin
         if ($urandom_range(0, 9) == 0) pending_params.push_back(T_BITS'($urandom));
         else pending_params.push_back(T_BITS'($urandom_range(0, 1 << PARAM_BITS)));
      end
   endtask

   initial begin
      foreach (ctrl_pts[i]) ctrl_pts[i] = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // reset values give a zero tangent everywhere
      pending_params = '{0, 1, 32768, 65536, 65537, 131071};
      drain();

      set_curve(CURVE_WIDE);
      pending_params = '{0, 1, 2, 16384, 32767, 32768, 49152, 65535, 65536,
                         65537, 98304, 131071, 17'h0AAAA, 17'h15555};
      add_random(140);
      drain();

      set_curve(CURVE_MAX);   add_random(60);  drain();
      set_curve(CURVE_MIN);   add_random(60);  drain();
      set_curve(CURVE_ALTERNATE); add_random(150); drain();
      set_curve(CURVE_LINE);  add_random(120); drain();
      set_curve(CURVE_NARROW); add_random(150); drain();
      for (int p = 0; p < 3; p++) begin
         set_curve(CURVE_WIDE);
         add_random(150);
         drain();
      end
      set_curve(CURVE_ZERO); add_random(20); drain();

      // last stretch runs back to back
      calm = 1'b1;
      set_curve(CURVE_WIDE);
      add_random(100);
      drain();

      if (errors == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

   initial begin
      #2000000;
      $display("FAILED: results differ");
      $finish;
   end

endmodule
